FILE: design/pcx_pkg.sv
// ----------------------------------------------------------------------------
// pcx_pkg: shared types and constants for the cycle crossover block
// City code widths, tour size defaults and the sizes derived from them.
// ----------------------------------------------------------------------------
package pcx_pkg;

    localparam int CITY_W         = 6;
    localparam int CITY_CODES     = 2 ** CITY_W;
    localparam int CITIES_DEFAULT = 64;

    typedef logic [CITY_W-1:0] city_t;

endpackage

FILE: design/pcx_if.sv
// ----------------------------------------------------------------------------
// pcx_parent_if / pcx_child_if: valid/ready channels of the crossover block
// One transaction moves one tour position of both parents or both children.
// ----------------------------------------------------------------------------
interface pcx_parent_if;
    import pcx_pkg::*;

    logic  valid;
    logic  ready;
    city_t first_parent_city;
    city_t second_parent_city;
    logic  last_position;

    modport source (output valid, output first_parent_city, output second_parent_city,
                    output last_position, input ready);
    modport sink   (input valid, input first_parent_city, input second_parent_city,
                    input last_position, output ready);
endinterface

interface pcx_child_if;
    import pcx_pkg::*;

    logic  valid;
    logic  ready;
    city_t tour_position;
    city_t first_child_city;
    city_t second_child_city;
    logic  last_result;

    modport source (output valid, output tour_position, output first_child_city,
                    output second_child_city, output last_result, input ready);
    modport sink   (input valid, input tour_position, input first_child_city,
                    input second_child_city, input last_result, output ready);
endinterface

FILE: design/pcx_ram.sv
// ----------------------------------------------------------------------------
// pcx_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcx_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/permutation_cycle_crossover.sv
// ----------------------------------------------------------------------------
// permutation_cycle_crossover: cycle crossover of two parent tours
// Loads both parents, walks the crossover cycle and emits both children.
// ----------------------------------------------------------------------------
// Usage:
//   parents : one transaction per tour position, both parents' cities side by
//             side; last_position closes the tour and starts the crossover.
//             Positions beyond CITIES are dropped, a late last still starts it.
//   children: one transaction per position, ascending, last_result on the last.
// Sequence:
//   Loading stores one position per accepted transaction. The cycle walk takes
//   one step per position of the cycle: a read of the second parent RAM, then
//   a read of the city-to-position RAM. Emission reads the parent RAMs, then
//   loads the output register, for each position. parents.ready is low from
//   the last load until the final result sits in the output register.
// Reset: clears the tour length, the position map valid bits, the cycle marks
//   and the output register. Parent RAM contents are never cleared.
// Stall: the output register holds its transaction while children.ready is
//   low; emission waits, no result is lost. Once the last result is in the
//   output register the next tour may load.
// ----------------------------------------------------------------------------
module permutation_cycle_crossover #(
    parameter int CITIES = pcx_pkg::CITIES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    pcx_parent_if.sink   parents,
    pcx_child_if.source  children
);
    import pcx_pkg::*;

    localparam int POS_W = $clog2(CITIES);
    localparam int CNT_W = $clog2(CITIES + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_CITY,
        S_NEXT,
        S_ERD,
        S_EOUT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CITY_CODES-1:0]   map_valid_reg;
    logic [CITIES-1:0]       mark_reg;
    logic                    city_valid_reg;
    logic [POS_W-1:0]        emit_idx_reg;

    logic                    out_valid_reg;
    city_t                   out_pos_reg;
    city_t                   out_first_reg;
    city_t                   out_second_reg;
    logic                    out_last_reg;

    logic                    in_accept;
    logic                    load_store;
    logic                    map_we;
    logic [POS_W-1:0]        p2_raddr;
    city_t                   p1_rdata;
    city_t                   p2_rdata;
    logic [POS_W-1:0]        map_rdata;
    logic                    out_free;
    logic                    on_cycle;
    logic                    emit_last;

    assign parents.ready = (state_reg == S_LOAD);
    assign in_accept     = parents.valid && parents.ready;
    assign load_store    = in_accept && (count_reg < CNT_W'(CITIES));
    assign map_we        = load_store && !map_valid_reg[parents.first_parent_city];

    assign out_free  = !out_valid_reg || children.ready;
    assign on_cycle  = mark_reg[emit_idx_reg];
    assign emit_last = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        unique case (state_reg)
            S_NEXT:        p2_raddr = map_rdata;
            S_ERD, S_EOUT: p2_raddr = emit_idx_reg;
            default:       p2_raddr = '0;
        endcase
    end

    pcx_ram #(.DEPTH(CITIES), .WIDTH(CITY_W)) u_first_parent (
        .clk   (clk),
        .we    (load_store),
        .waddr (count_reg[POS_W-1:0]),
        .wdata (parents.first_parent_city),
        .raddr (emit_idx_reg),
        .rdata (p1_rdata)
    );

    pcx_ram #(.DEPTH(CITIES), .WIDTH(CITY_W)) u_second_parent (
        .clk   (clk),
        .we    (load_store),
        .waddr (count_reg[POS_W-1:0]),
        .wdata (parents.second_parent_city),
        .raddr (p2_raddr),
        .rdata (p2_rdata)
    );

    // first position of each city in the first parent; valid bits mark a match
    pcx_ram #(.DEPTH(CITY_CODES), .WIDTH(POS_W)) u_city_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (parents.first_parent_city),
        .wdata (count_reg[POS_W-1:0]),
        .raddr (p2_rdata),
        .rdata (map_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            map_valid_reg  <= '0;
            mark_reg       <= '0;
            city_valid_reg <= 1'b0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // S_EOUT reloads the register itself whenever the receiver takes it
            if (children.ready && state_reg != S_EOUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (load_store)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (map_we)
                    begin
                        map_valid_reg[parents.first_parent_city] <= 1'b1;
                    end
                    if (in_accept && parents.last_position)
                    begin
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    // position 0 always opens the cycle
                    mark_reg[0] <= 1'b1;
                    state_reg   <= S_CITY;
                end
                S_CITY:
                begin
                    city_valid_reg <= map_valid_reg[p2_rdata];
                    state_reg      <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (city_valid_reg && !mark_reg[map_rdata])
                    begin
                        mark_reg[map_rdata] <= 1'b1;
                        state_reg           <= S_CITY;
                    end
                    else
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= S_ERD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EOUT;
                end
                S_EOUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_pos_reg    <= CITY_W'(emit_idx_reg);
                        out_first_reg  <= on_cycle ? p1_rdata : p2_rdata;
                        out_second_reg <= on_cycle ? p2_rdata : p1_rdata;
                        out_last_reg   <= emit_last;
                        if (emit_last)
                        begin
                            count_reg     <= '0;
                            map_valid_reg <= '0;
                            mark_reg      <= '0;
                            state_reg     <= S_LOAD;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + POS_W'(1);
                            state_reg    <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign children.valid             = out_valid_reg;
    assign children.tour_position     = out_pos_reg;
    assign children.first_child_city  = out_first_reg;
    assign children.second_child_city = out_second_reg;
    assign children.last_result       = out_last_reg;

endmodule
